FILE: design/epc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_pkg
// Widths, constants and the stage-to-stage bundle for the elastic collision
// pipeline.
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int VEL_W  = 32;
  localparam int MASS_W = 24;
  localparam int NRM_W  = 16;
  localparam int NFRAC  = 14;
  localparam int WFRAC  = 30;

  // Weight quotient: Q2.30, at most 2.0.
  localparam int WQ_W  = WFRAC + 2;
  localparam int N_W   = MASS_W + WQ_W;
  localparam int REM_W = MASS_W + 2;

  localparam int DV_W = VEL_W + 1;
  localparam int T_W  = DV_W + NRM_W;
  localparam int TS_W = T_W + 2;
  localparam int D_W  = TS_W - NFRAC;

  localparam int DOT_STG = 3;
  localparam int LAT_DIV = WQ_W + 1;
  localparam int RES_STG = 4;
  localparam int LATENCY = LAT_DIV + RES_STG;

  localparam logic signed [NRM_W-1:0] NRM_POS = NRM_W'(1 << NFRAC);
  localparam logic signed [NRM_W-1:0] NRM_NEG = -NRM_POS;
  localparam logic [WQ_W-1:0]         W_ONE   = WQ_W'(1) << WFRAC;

  typedef struct packed {
    logic                          valid;
    logic                          zero;
    logic [D_W-1:0]                d;
    logic [2:0][VEL_W-1:0]         v1;
    logic [2:0][VEL_W-1:0]         v2;
    logic [2:0][NRM_W-1:0]         n;
  } dot_out_t;

endpackage

FILE: design/epc_wdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_wdiv
// Pipelined restoring divider for both mass weights 2m/(ma+mb) in Q2.30,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module epc_wdiv (
  input  logic                       clk,
  input  logic [epc_pkg::MASS_W-1:0] mass_a,
  input  logic [epc_pkg::MASS_W-1:0] mass_b,
  output logic [epc_pkg::WQ_W-1:0]   w1,
  output logic [epc_pkg::WQ_W-1:0]   w2
);
  import epc_pkg::*;

  logic [MASS_W:0]  msum;
  logic [N_W-1:0]   num_a, num_b;

  logic [REM_W-1:0] rem_a_r [WQ_W+1];
  logic [REM_W-1:0] rem_b_r [WQ_W+1];
  logic [WQ_W-1:0]  lo_a_r  [WQ_W+1];
  logic [WQ_W-1:0]  lo_b_r  [WQ_W+1];
  logic [MASS_W:0]  sum_r   [WQ_W+1];
  logic             eq_r    [WQ_W+1];

  // Rounding to nearest is folded into the dividend as half the divisor.
  always_comb begin
    msum  = {1'b0, mass_a} + {1'b0, mass_b};
    num_a = N_W'({mass_a, {(WFRAC+1){1'b0}}}) + N_W'(msum >> 1);
    num_b = N_W'({mass_b, {(WFRAC+1){1'b0}}}) + N_W'(msum >> 1);
  end

  always_ff @(posedge clk) begin
    rem_a_r[0] <= REM_W'(num_a[N_W-1:WQ_W]);
    rem_b_r[0] <= REM_W'(num_b[N_W-1:WQ_W]);
    lo_a_r[0]  <= num_a[WQ_W-1:0];
    lo_b_r[0]  <= num_b[WQ_W-1:0];
    sum_r[0]   <= msum;
    eq_r[0]    <= (mass_a == mass_b);
  end

  for (genvar k = 1; k <= WQ_W; k++) begin : g_step
    logic [REM_W-1:0] sh_a, sh_b;
    logic             ge_a, ge_b;

    always_comb begin
      sh_a = {rem_a_r[k-1][REM_W-2:0], lo_a_r[k-1][WQ_W-1]};
      sh_b = {rem_b_r[k-1][REM_W-2:0], lo_b_r[k-1][WQ_W-1]};
      ge_a = (sh_a >= REM_W'(sum_r[k-1]));
      ge_b = (sh_b >= REM_W'(sum_r[k-1]));
    end

    always_ff @(posedge clk) begin
      rem_a_r[k] <= ge_a ? sh_a - REM_W'(sum_r[k-1]) : sh_a;
      rem_b_r[k] <= ge_b ? sh_b - REM_W'(sum_r[k-1]) : sh_b;
      lo_a_r[k]  <= {lo_a_r[k-1][WQ_W-2:0], ge_a};
      lo_b_r[k]  <= {lo_b_r[k-1][WQ_W-2:0], ge_b};
      sum_r[k]   <= sum_r[k-1];
      eq_r[k]    <= eq_r[k-1];
    end
  end

  // Equal masses, zero included, give exactly 1.0 for both weights.
  assign w1 = eq_r[WQ_W] ? W_ONE : lo_a_r[WQ_W];
  assign w2 = eq_r[WQ_W] ? W_ONE : lo_b_r[WQ_W];

endmodule

FILE: design/epc_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_dot
// Clamps the normal, forms d = n.(v2 - v1) rounded to Q21.16 and delays the
// beat so that it meets the weights from the divider.
// ----------------------------------------------------------------------------
module epc_dot (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [2:0][epc_pkg::VEL_W-1:0]    v1,
  input  logic [2:0][epc_pkg::VEL_W-1:0]    v2,
  input  logic [2:0][epc_pkg::NRM_W-1:0]    nrm,
  output epc_pkg::dot_out_t                 dout
);
  import epc_pkg::*;

  localparam int DLY = LAT_DIV - DOT_STG;

  logic signed [NRM_W-1:0] ncl [3];
  logic signed [DV_W-1:0]  dv  [3];
  logic                    zero_nxt;

  logic                    vld0_r, vld1_r;
  logic                    zero0_r, zero1_r;
  logic [2:0][VEL_W-1:0]   v1_0_r, v2_0_r, v1_1_r, v2_1_r;
  logic [2:0][NRM_W-1:0]   n0_r, n1_r;
  logic signed [NRM_W-1:0] ns0_r [3];
  logic signed [DV_W-1:0]  dv0_r [3];
  logic signed [T_W-1:0]   t1_r  [3];
  logic [TS_W-1:0]         tsum;

  dot_out_t st2_r;
  dot_out_t dly_r [DLY];

  always_comb begin
    zero_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ($signed(nrm[i]) > NRM_POS) begin
        ncl[i] = NRM_POS;
      end else if ($signed(nrm[i]) < NRM_NEG) begin
        ncl[i] = NRM_NEG;
      end else begin
        ncl[i] = $signed(nrm[i]);
      end
      if (nrm[i] != '0) begin
        zero_nxt = 1'b0;
      end
      dv[i] = DV_W'($signed(v2[i])) - DV_W'($signed(v1[i]));
    end
  end

  // The sum of floors plus the rounded remainder is floor((T + half) / 2^14).
  always_comb begin
    tsum = TS_W'(t1_r[0]) + TS_W'(t1_r[1]) + TS_W'(t1_r[2])
         + (TS_W'(1) << (NFRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r      <= 1'b0;
      vld1_r      <= 1'b0;
      st2_r.valid <= 1'b0;
      for (int k = 0; k < DLY; k++) begin
        dly_r[k].valid <= 1'b0;
      end
    end else begin
      vld0_r      <= in_valid;
      vld1_r      <= vld0_r;
      st2_r.valid <= vld1_r;
      dly_r[0].valid <= st2_r.valid;
      for (int k = 1; k < DLY; k++) begin
        dly_r[k].valid <= dly_r[k-1].valid;
      end
    end

    zero0_r <= zero_nxt;
    v1_0_r  <= v1;
    v2_0_r  <= v2;
    for (int i = 0; i < 3; i++) begin
      ns0_r[i] <= ncl[i];
      n0_r[i]  <= ncl[i];
      dv0_r[i] <= dv[i];
    end

    zero1_r <= zero0_r;
    v1_1_r  <= v1_0_r;
    v2_1_r  <= v2_0_r;
    n1_r    <= n0_r;
    for (int i = 0; i < 3; i++) begin
      t1_r[i] <= T_W'(ns0_r[i]) * T_W'(dv0_r[i]);
    end

    st2_r.zero <= zero1_r;
    st2_r.d    <= tsum[TS_W-1:NFRAC];
    st2_r.v1   <= v1_1_r;
    st2_r.v2   <= v2_1_r;
    st2_r.n    <= n1_r;

    dly_r[0].zero <= st2_r.zero;
    dly_r[0].d    <= st2_r.d;
    dly_r[0].v1   <= st2_r.v1;
    dly_r[0].v2   <= st2_r.v2;
    dly_r[0].n    <= st2_r.n;
    for (int k = 1; k < DLY; k++) begin
      dly_r[k].zero <= dly_r[k-1].zero;
      dly_r[k].d    <= dly_r[k-1].d;
      dly_r[k].v1   <= dly_r[k-1].v1;
      dly_r[k].v2   <= dly_r[k-1].v2;
      dly_r[k].n    <= dly_r[k-1].n;
    end
  end

  assign dout = dly_r[DLY-1];

endmodule

FILE: design/epc_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_resolve
// Scales d by the weights, projects back onto the normal, adds to v1,
// subtracts from v2 and saturates; a zero normal passes both through.
// ----------------------------------------------------------------------------
module epc_resolve (
  input  logic                             clk,
  input  logic                             rst_n,
  input  epc_pkg::dot_out_t                din,
  input  logic [epc_pkg::WQ_W-1:0]         w1,
  input  logic [epc_pkg::WQ_W-1:0]         w2,
  output logic                             res_valid,
  output logic [2:0][epc_pkg::VEL_W-1:0]   nv1,
  output logic [2:0][epc_pkg::VEL_W-1:0]   nv2,
  output logic                             res_null
);
  import epc_pkg::*;

  localparam int DL_W = (D_W + 1) / 2;
  localparam int DH_W = D_W - DL_W;
  localparam int P_W  = D_W + WQ_W + 1;
  localparam int G_W  = P_W - WFRAC;
  localparam int NM_W = NFRAC + 1;
  localparam int PQ_W = G_W + NM_W + 1;
  localparam int Q_W  = PQ_W - NFRAC;
  localparam int S_W  = Q_W + 2;

  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [S_W-1:0] s);
    logic signed [S_W-1:0] hi;
    logic signed [S_W-1:0] lo;
    hi = S_W'({1'b0, {(VEL_W-1){1'b1}}});
    lo = -hi - S_W'(1);
    if (s > hi) begin
      return hi[VEL_W-1:0];
    end else if (s < lo) begin
      return lo[VEL_W-1:0];
    end
    return s[VEL_W-1:0];
  endfunction

  dot_out_t side_r [3];

  logic [D_W-1:0]       dmag;
  logic [DH_W+WQ_W-1:0] ph1_r, ph2_r;
  logic [DL_W+WQ_W-1:0] pl1_r, pl2_r;
  logic [P_W-1:0]       p1, p2;
  logic [G_W-1:0]       g1_r, g2_r;
  logic [NM_W-1:0]      nmag [3];
  logic [G_W+NM_W-1:0]  pa_r [3];
  logic [G_W+NM_W-1:0]  pb_r [3];

  logic [PQ_W-1:0]         ra, rb;
  logic signed [Q_W:0]     qa, qb;
  logic                    neg;
  logic [2:0][VEL_W-1:0]   nv1_nxt, nv2_nxt;

  logic                    vld_r;
  logic [2:0][VEL_W-1:0]   nv1_r, nv2_r;
  logic                    null_r;

  always_comb begin
    dmag = din.d[D_W-1] ? -din.d : din.d;
  end

  always_comb begin
    p1 = (P_W'(ph1_r) << DL_W) + P_W'(pl1_r) + (P_W'(1) << (WFRAC - 1));
    p2 = (P_W'(ph2_r) << DL_W) + P_W'(pl2_r) + (P_W'(1) << (WFRAC - 1));
    for (int i = 0; i < 3; i++) begin
      nmag[i] = side_r[1].n[i][NRM_W-1] ? NM_W'(-side_r[1].n[i])
                                        : NM_W'(side_r[1].n[i]);
    end
  end

  // Rounding is on magnitudes, so ties go away from zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg = side_r[2].d[D_W-1] ^ side_r[2].n[i][NRM_W-1];
      ra  = PQ_W'(pa_r[i]) + (PQ_W'(1) << (NFRAC - 1));
      rb  = PQ_W'(pb_r[i]) + (PQ_W'(1) << (NFRAC - 1));
      qa  = $signed({1'b0, ra[PQ_W-1:NFRAC]});
      qb  = $signed({1'b0, rb[PQ_W-1:NFRAC]});
      if (neg) begin
        qa = -qa;
        qb = -qb;
      end
      if (side_r[2].zero) begin
        nv1_nxt[i] = side_r[2].v1[i];
        nv2_nxt[i] = side_r[2].v2[i];
      end else begin
        nv1_nxt[i] = sat_vel(S_W'($signed(side_r[2].v1[i])) + S_W'(qa));
        nv2_nxt[i] = sat_vel(S_W'($signed(side_r[2].v2[i])) - S_W'(qb));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0].valid <= 1'b0;
      side_r[1].valid <= 1'b0;
      side_r[2].valid <= 1'b0;
      vld_r           <= 1'b0;
    end else begin
      side_r[0].valid <= din.valid;
      side_r[1].valid <= side_r[0].valid;
      side_r[2].valid <= side_r[1].valid;
      vld_r           <= side_r[2].valid;
    end

    side_r[0].zero <= din.zero;
    side_r[0].d    <= din.d;
    side_r[0].v1   <= din.v1;
    side_r[0].v2   <= din.v2;
    side_r[0].n    <= din.n;
    for (int k = 1; k < 3; k++) begin
      side_r[k].zero <= side_r[k-1].zero;
      side_r[k].d    <= side_r[k-1].d;
      side_r[k].v1   <= side_r[k-1].v1;
      side_r[k].v2   <= side_r[k-1].v2;
      side_r[k].n    <= side_r[k-1].n;
    end

    ph1_r <= (DH_W+WQ_W)'(dmag[D_W-1:DL_W]) * (DH_W+WQ_W)'(w1);
    pl1_r <= (DL_W+WQ_W)'(dmag[DL_W-1:0]) * (DL_W+WQ_W)'(w1);
    ph2_r <= (DH_W+WQ_W)'(dmag[D_W-1:DL_W]) * (DH_W+WQ_W)'(w2);
    pl2_r <= (DL_W+WQ_W)'(dmag[DL_W-1:0]) * (DL_W+WQ_W)'(w2);

    g1_r <= p1[P_W-1:WFRAC];
    g2_r <= p2[P_W-1:WFRAC];

    // Particle one moves by +w2*d*n, particle two by -w1*d*n.
    for (int i = 0; i < 3; i++) begin
      pa_r[i] <= (G_W+NM_W)'(g2_r) * (G_W+NM_W)'(nmag[i]);
      pb_r[i] <= (G_W+NM_W)'(g1_r) * (G_W+NM_W)'(nmag[i]);
    end

    nv1_r  <= nv1_nxt;
    nv2_r  <= nv2_nxt;
    null_r <= side_r[2].zero;
  end

  assign res_valid = vld_r;
  assign nv1       = nv1_r;
  assign nv2       = nv2_r;
  assign res_null  = null_r;

endmodule

FILE: design/elastic_particle_collision_3d.sv
`timescale 1ns / 1ps
// The result path runs through the 32-stage weight divider plus its input
// register, then four result stages.
// Throughput: one beat per cycle; busy is low whenever reset is released.
// Reset (rst_n low, synchronous) clears the valid bits of every stage and holds
// busy high; beats in flight are dropped. The receiver cannot stall.
// ----------------------------------------------------------------------------
// elastic_particle_collision_3d
// Two-body elastic collision in 3D, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module elastic_particle_collision_3d (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [epc_pkg::VEL_W-1:0]   in_vel1_x,
  input  logic [epc_pkg::VEL_W-1:0]   in_vel1_y,
  input  logic [epc_pkg::VEL_W-1:0]   in_vel1_z,
  input  logic [epc_pkg::VEL_W-1:0]   in_vel2_x,
  input  logic [epc_pkg::VEL_W-1:0]   in_vel2_y,
  input  logic [epc_pkg::VEL_W-1:0]   in_vel2_z,
  input  logic [epc_pkg::NRM_W-1:0]   in_normal_x,
  input  logic [epc_pkg::NRM_W-1:0]   in_normal_y,
  input  logic [epc_pkg::NRM_W-1:0]   in_normal_z,
  input  logic [epc_pkg::MASS_W-1:0]  in_mass_a,
  input  logic [epc_pkg::MASS_W-1:0]  in_mass_b,
  output logic                        out_valid,
  output logic [epc_pkg::VEL_W-1:0]   out_new_vel1_x,
  output logic [epc_pkg::VEL_W-1:0]   out_new_vel1_y,
  output logic [epc_pkg::VEL_W-1:0]   out_new_vel1_z,
  output logic [epc_pkg::VEL_W-1:0]   out_new_vel2_x,
  output logic [epc_pkg::VEL_W-1:0]   out_new_vel2_y,
  output logic [epc_pkg::VEL_W-1:0]   out_new_vel2_z,
  output logic                        out_normal_null
);
  import epc_pkg::*;

  logic                  in_valid;
  logic [WQ_W-1:0]       w1, w2;
  dot_out_t              dot;
  logic [2:0][VEL_W-1:0] nv1, nv2;

  assign busy     = ~rst_n;
  assign in_valid = start & ~busy;

  epc_wdiv u_wdiv (
    .clk    (clk),
    .mass_a (in_mass_a),
    .mass_b (in_mass_b),
    .w1     (w1),
    .w2     (w2)
  );

  epc_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .v1       ({in_vel1_z, in_vel1_y, in_vel1_x}),
    .v2       ({in_vel2_z, in_vel2_y, in_vel2_x}),
    .nrm      ({in_normal_z, in_normal_y, in_normal_x}),
    .dout     (dot)
  );

  epc_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .din       (dot),
    .w1        (w1),
    .w2        (w2),
    .res_valid (out_valid),
    .nv1       (nv1),
    .nv2       (nv2),
    .res_null  (out_normal_null)
  );

  assign out_new_vel1_x = nv1[0];
  assign out_new_vel1_y = nv1[1];
  assign out_new_vel1_z = nv1[2];
  assign out_new_vel2_x = nv2[0];
  assign out_new_vel2_y = nv2[1];
  assign out_new_vel2_z = nv2[2];

endmodule

FILE: design/epc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_checker
// Port-level checks on beat timing and the zero-normal pass-through.
// ----------------------------------------------------------------------------
module epc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [epc_pkg::VEL_W-1:0]   in_vel1_x,
  input logic [epc_pkg::NRM_W-1:0]   in_normal_x,
  input logic [epc_pkg::NRM_W-1:0]   in_normal_y,
  input logic [epc_pkg::NRM_W-1:0]   in_normal_z,
  input logic                        out_valid,
  input logic [epc_pkg::VEL_W-1:0]   out_new_vel1_x,
  input logic                        out_normal_null
);
  import epc_pkg::*;

  a_never_busy : assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_beat_out : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted beat produced no result");

  a_no_extra : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without an accepted beat");

  a_null_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_normal_null == $past((in_normal_x == '0) &&
      (in_normal_y == '0) && (in_normal_z == '0), LATENCY)))
    else $error("zero-normal flag mismatch");

  a_null_pass : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_normal_null) |-> (out_new_vel1_x == $past(in_vel1_x, LATENCY)))
    else $error("zero normal did not pass velocity through");

endmodule

bind elastic_particle_collision_3d epc_checker u_epc_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3D elastic collision pipeline. A directed set
// covers zero, over-range and non-unit normals, equal and zero masses and
// saturation, then random collision beats follow under several idle patterns.
// Every result is compared field by field with a bit-exact predictor.
// ----------------------------------------------------------------------------
module testbench;
  import epc_pkg::*;

  localparam int LIMIT = 400000;
  localparam logic signed [NRM_W-1:0] NRM_MAX = 16'sh7fff;
  localparam logic signed [NRM_W-1:0] NRM_MIN = 16'sh8000;

  typedef struct packed {
    logic [2:0][VEL_W-1:0] v1;
    logic [2:0][VEL_W-1:0] v2;
    logic [2:0][NRM_W-1:0] n;
    logic [MASS_W-1:0]     ma;
    logic [MASS_W-1:0]     mb;
  } collision_t;

  typedef struct packed {
    logic [5:0][VEL_W-1:0] vel;
    logic                  null_n;
  } bounce_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  collision_t drv = '0;
  logic out_valid;
  logic [VEL_W-1:0] o1x, o1y, o1z, o2x, o2y, o2z;
  logic out_normal_null;

  collision_t pending_q[$];
  bounce_t    bounce_q[$];
  int idle_pct = 0;
  int cycles = 0;
  bit failed = 1'b0;

  elastic_particle_collision_3d dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vel1_x(drv.v1[0]), .in_vel1_y(drv.v1[1]), .in_vel1_z(drv.v1[2]),
    .in_vel2_x(drv.v2[0]), .in_vel2_y(drv.v2[1]), .in_vel2_z(drv.v2[2]),
    .in_normal_x(drv.n[0]), .in_normal_y(drv.n[1]), .in_normal_z(drv.n[2]),
    .in_mass_a(drv.ma), .in_mass_b(drv.mb),
    .out_valid(out_valid),
    .out_new_vel1_x(o1x), .out_new_vel1_y(o1y), .out_new_vel1_z(o1z),
    .out_new_vel2_x(o2x), .out_new_vel2_y(o2y), .out_new_vel2_z(o2z),
    .out_normal_null(out_normal_null)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // round(a*b / 2^f) with ties away from zero, magnitude capped at 2^62
  function automatic longint scaled_product(longint a, longint b, int f);
    logic [127:0] mag;
    logic [127:0] ua, ub;
    begin
      ua = (a < 0) ? 128'(-a) : 128'(a);
      ub = (b < 0) ? 128'(-b) : 128'(b);
      mag = ((ua * ub) + (128'd1 << (f - 1))) >> f;
      if (mag > (128'd1 << 62)) mag = 128'd1 << 62;
      return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
    end
  endfunction

  function automatic logic [VEL_W-1:0] clamp_vel(longint v);
    longint hi, lo;
    begin
      hi = (longint'(1) <<< (VEL_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[VEL_W-1:0];
    end
  endfunction

  function automatic bounce_t resolve_collision(collision_t c);
    bounce_t r;
    longint v1[3], v2[3], n[3];
    longint t, q, qsum, rsum, d, g1, g2, sum, w1, w2;
    bit zero;
    begin
      zero = 1'b1;
      qsum = 0;
      rsum = 0;
      for (int i = 0; i < 3; i++) begin
        v1[i] = longint'($signed(c.v1[i]));
        v2[i] = longint'($signed(c.v2[i]));
        n[i] = longint'($signed(c.n[i]));
        if (n[i] != 0) zero = 1'b0;
        if (n[i] > 16384) n[i] = 16384;
        if (n[i] < -16384) n[i] = -16384;
      end
      if (zero) begin
        r.vel = {c.v2, c.v1};
        r.null_n = 1'b1;
        return r;
      end
      for (int i = 0; i < 3; i++) begin
        t = n[i] * (v2[i] - v1[i]);
        q = t >>> NFRAC;
        qsum += q;
        rsum += t - (q <<< NFRAC);
      end
      d = qsum + ((rsum + 8192) >>> NFRAC);
      if (c.ma == c.mb) begin
        w1 = longint'(1) <<< WFRAC;
        w2 = w1;
      end else begin
        sum = longint'(c.ma) + longint'(c.mb);
        w1 = (((longint'(c.ma) * 2) <<< WFRAC) + sum / 2) / sum;
        w2 = (((longint'(c.mb) * 2) <<< WFRAC) + sum / 2) / sum;
      end
      g1 = scaled_product(d, w1, WFRAC);
      g2 = scaled_product(d, w2, WFRAC);
      for (int i = 0; i < 3; i++) begin
        r.vel[i] = clamp_vel(v1[i] + scaled_product(g2, n[i], NFRAC));
        r.vel[3 + i] = clamp_vel(v2[i] - scaled_product(g1, n[i], NFRAC));
      end
      r.null_n = 1'b0;
      return r;
    end
  endfunction

  // Driver: a beat is presented at the falling edge and held until taken.
  always @(negedge clk) begin
    if (rst_n && pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      drv <= pending_q[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Acceptance and result checking at the rising edge.
  always @(posedge clk) begin
    bounce_t want, got;
    cycles <= cycles + 1;
    if (rst_n && start && !busy) begin
      bounce_q.push_back(resolve_collision(drv));
      void'(pending_q.pop_front());
    end
    if (rst_n && out_valid) begin
      got.vel = {o2z, o2y, o2x, o1z, o1y, o1x};
      got.null_n = out_normal_null;
      if (bounce_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        failed = 1'b1;
      end else begin
        want = bounce_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (want.vel[i] !== got.vel[i]) begin
            $display("%0t: velocity %0d expected %h actual %h", $time, i,
                     want.vel[i], got.vel[i]);
            failed = 1'b1;
          end
        if (want.null_n !== got.null_n) begin
          $display("%0t: normal_null expected %b actual %b", $time,
                   want.null_n, got.null_n);
          failed = 1'b1;
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("[elastic_particle_collision_3d] ERROR");
      $finish;
    end
  end

  task automatic add_beat(logic [31:0] a, logic [31:0] b, logic [15:0] nx,
                          logic [15:0] ny, logic [15:0] nz,
                          logic [23:0] ma, logic [23:0] mb);
    collision_t c;
    c.v1 = {a ^ 32'h1234, -a, a};
    c.v2 = {b, b ^ 32'h00ff_0000, -b};
    c.n = {nz, ny, nx};
    c.ma = ma;
    c.mb = mb;
    pending_q.push_back(c);
  endtask

  function automatic logic [15:0] unit_component();
    case ($urandom_range(5))
      0: return 16'(NRM_POS);
      1: return 16'(NRM_NEG);
      2: return 16'h0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic add_random();
    collision_t c;
    for (int i = 0; i < 3; i++) begin
      c.v1[i] = ($urandom_range(3) == 0) ? $urandom() : 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      c.v2[i] = ($urandom_range(3) == 0) ? $urandom() : 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      c.n[i] = ($urandom_range(9) == 0) ? 16'($urandom()) : unit_component();
    end
    if ($urandom_range(19) == 0) c.n = '0;
    c.ma = ($urandom_range(1) == 0) ? 24'($urandom()) : 24'($urandom_range(1000));
    c.mb = ($urandom_range(4) == 0) ? c.ma :
           (($urandom_range(1) == 0) ? 24'($urandom()) : 24'($urandom_range(1000)));
    pending_q.push_back(c);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || bounce_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    int pct[4] = '{0, 81, 0, 32};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: zero normal, equal and zero masses, over-range normals,
    // non-unit normals, extreme velocities that saturate, extreme masses.
    add_beat(32'h0001_0000, 32'hffff_0000, 16'h0, 16'h0, 16'h0, 24'd5, 24'd7);
    add_beat(32'h7fff_ffff, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 24'd0, 24'd0);
    add_beat(32'h0003_0000, 32'hfffd_0000, NRM_POS, 16'h0, 16'h0, 24'd10, 24'd10);
    add_beat(32'h0003_0000, 32'hfffd_0000, 16'h0, NRM_NEG, 16'h0, 24'd0, 24'd0);
    add_beat(32'h0002_0000, 32'h0005_0000, 16'h0, 16'h0, NRM_POS, 24'd0, 24'd9);
    add_beat(32'h0002_0000, 32'h0005_0000, NRM_MAX, NRM_MIN, 16'h4000, 24'd3, 24'd1);
    add_beat(32'h0012_3456, 32'hfedc_ba98, 16'h2d41, 16'h2d41, 16'h0, 24'hffffff, 24'd1);
    add_beat(32'h7fff_ffff, 32'h8000_0000, NRM_POS, NRM_POS, NRM_POS, 24'd1, 24'hffffff);
    add_beat(32'h8000_0000, 32'h7fff_ffff, NRM_NEG, NRM_NEG, NRM_NEG, 24'hffffff, 24'hffffff);
    add_beat(32'h8000_0000, 32'h7fff_ffff, 16'h0001, 16'hffff, 16'h0, 24'hffffff, 24'hfffffe);
    add_beat(32'hffff_ffff, 32'h0000_0001, 16'h24f3, 16'hdb0d, 16'h24f3, 24'd1, 24'd2);
    add_beat(32'h5555_5555, 32'haaaa_aaaa, 16'h1000, 16'h1000, 16'h1000, 24'h800000, 24'd0);
    add_beat(32'h0, 32'h0, NRM_POS, 16'h0, 16'h0, 24'd4, 24'd4);
    drain();
    foreach (pct[p]) begin
      idle_pct = pct[p];
      repeat (185) add_random();
      // wait until every beat of the phase is taken and checked
      drain();
    end
    if (!failed) begin
      $display("[elastic_particle_collision_3d] OK");
    end else begin
      $display("[elastic_particle_collision_3d] ERROR");
    end
    $finish;
  end

endmodule
